>>> hdl/ppt_pkg.sv
// ============================================================================
// ppt_pkg
// Shared widths, register map and reset values for the point projection
// transform unit.
// ============================================================================
package ppt_pkg;

    // Register map: eight 64-bit coefficient registers at 8-byte spacing.
    localparam int NumRegs  = 8;
    localparam int RegIdxW  = 3;
    localparam int AddrW    = 6;
    localparam int DataW    = 64;

    // Arithmetic widths.
    localparam int CoefW    = 32;
    localparam int ProdW    = 64;                // signed 32x32 product
    localparam int PairW    = 65;                // sum of two products
    localparam int SumW     = 67;                // Q32.32 row sum, exact
    localparam int FracSh   = 16;                // Q32.32 to Q16.16 shift
    localparam int NumW     = SumW + FracSh;     // scaled numerator magnitude
    localparam int QuotW    = 32;                // quotient bits computed
    localparam int RemW     = SumW + QuotW;      // widest shifted divisor

    // Pipeline layout: products, pair sums, row sums, magnitudes,
    // overflow check, one stage per quotient bit, output register.
    localparam int DivFirst = 5;
    localparam int NumStg   = DivFirst + QuotW + 1;

    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;

    // Register indexes.
    typedef enum logic [RegIdxW-1:0] {
        REG_ROW0_A, REG_ROW0_B, REG_ROW1_A, REG_ROW1_B,
        REG_ROW2_A, REG_ROW2_B, REG_ROW3_A, REG_ROW3_B
    } t_reg_idx;

    // Reset matrix is the identity in Q16.16.
    localparam logic [DataW-1:0] RegRst [NumRegs] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

endpackage

>>> hdl/point_projection_transform_unit.sv
// ============================================================================
// point_projection_transform_unit
// Multiplies a Q16.16 point (w = 1) by a 4x4 Q16.16 matrix and divides
// x, y, z by w with truncation and saturation.
// ============================================================================
//  Channel  | Direction | Beat contents
//  s_axis   | in        | tdata: px[31:0], py[63:32], pz[95:64]
//  m_axis   | out       | tdata: qx, qy, qz; tuser: zero_w[0], clipped[1]
//  APB      | in/out    | eight 64-bit coefficient registers at 8*i
//
// One beat is accepted every cycle unless a stall backs up to the input.
// The divider sets the depth; it resolves one quotient bit per stage.
// Reset loads the identity matrix and empties the pipeline.
// Each stage holds its beat when the stage after it is full and stalled,
// so bubbles close up and nothing is lost or repeated.
module point_projection_transform_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [95:0]                  s_axis_tdata,  // px, py, pz
    // Output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [95:0]                  m_axis_tdata,  // qx, qy, qz
    output logic [1:0]                   m_axis_tuser,  // zero_w, clipped
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppt_pkg::AddrW-1:0]    paddr,
    input  logic [ppt_pkg::DataW-1:0]    pwdata,
    output logic [ppt_pkg::DataW-1:0]    prdata,
    output logic                         pready
);

    localparam int NS = ppt_pkg::NumStg;
    localparam int DF = ppt_pkg::DivFirst;
    localparam int QW = ppt_pkg::QuotW;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ppt_pkg::DataW-1:0] r_regs [ppt_pkg::NumRegs];
    logic [ppt_pkg::RegIdxW-1:0] w_idx;

    assign w_idx  = paddr[ppt_pkg::AddrW-1:3];
    assign pready = 1'b1;
    assign prdata = r_regs[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppt_pkg::NumRegs; i++) r_regs[i] <= ppt_pkg::RegRst[i];
        end else if (psel && penable && pwrite && pready) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    // Coefficient k of row r.
    logic [31:0] w_coef [4][4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_coef[r][0] = r_regs[2*r][31:0];
            w_coef[r][1] = r_regs[2*r][63:32];
            w_coef[r][2] = r_regs[2*r+1][31:0];
            w_coef[r][3] = r_regs[2*r+1][63:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage enables.
    // ------------------------------------------------------------------
    logic          r_vld [NS];
    logic [NS-1:0] w_en;

    assign w_en[NS-1] = !r_vld[NS-1] || m_axis_tready;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign w_en[s] = !r_vld[s] || w_en[s+1];
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
        end else begin
            if (w_en[0]) r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: products of coefficients and point coordinates.
    // ------------------------------------------------------------------
    logic signed [ppt_pkg::ProdW-1:0] r_prod [4][3];
    logic        [31:0]               r_off  [4];
    logic signed [31:0]               w_pt   [3];

    assign w_pt[0] = s_axis_tdata[31:0];
    assign w_pt[1] = s_axis_tdata[63:32];
    assign w_pt[2] = s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r][k] <= $signed(w_coef[r][k]) * w_pt[k];
                end
                r_off[r] <= w_coef[r][3];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pair sums; the w=1 term is the coefficient shifted to Q32.32.
    // ------------------------------------------------------------------
    logic signed [ppt_pkg::PairW-1:0] r_pa [4];
    logic signed [ppt_pkg::PairW-1:0] r_pb [4];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int r = 0; r < 4; r++) begin
                r_pa[r] <= r_prod[r][0] + r_prod[r][1];
                r_pb[r] <= r_prod[r][2] +
                           $signed({{17{r_off[r][31]}}, r_off[r], 16'b0});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: full row sums.
    // ------------------------------------------------------------------
    logic signed [ppt_pkg::SumW-1:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int r = 0; r < 4; r++) r_sum[r] <= r_pa[r] + r_pb[r];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes, signs and zero flags.
    // ------------------------------------------------------------------
    logic [ppt_pkg::SumW-1:0] r_nmag [3];
    logic [ppt_pkg::SumW-1:0] r_dmag;
    logic                     r_qneg [3];
    logic                     r_nneg [3];
    logic                     r_nzer [3];
    logic                     r_wzer;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r_nmag[k] <= r_sum[k][ppt_pkg::SumW-1] ? -r_sum[k] : r_sum[k];
                r_nneg[k] <= r_sum[k][ppt_pkg::SumW-1];
                r_qneg[k] <= r_sum[k][ppt_pkg::SumW-1] ^ r_sum[3][ppt_pkg::SumW-1];
                r_nzer[k] <= (r_sum[k] == '0);
            end
            r_dmag <= r_sum[3][ppt_pkg::SumW-1] ? -r_sum[3] : r_sum[3];
            r_wzer <= (r_sum[3] == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: quotient overflow check and divider setup.
    // The quotient fits in 32 bits exactly when |n| < |w| * 2^16.
    // ------------------------------------------------------------------
    logic [ppt_pkg::NumW-1:0] r_rem  [QW+1][3];
    logic [QW-1:0]            r_quo  [QW+1][3];
    logic [ppt_pkg::SumW-1:0] r_den  [QW+1];
    logic                     r_ovf  [QW+1][3];
    logic                     r_dqn  [QW+1][3];
    logic                     r_dnn  [QW+1][3];
    logic                     r_dnz  [QW+1][3];
    logic                     r_dwz  [QW+1];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= {r_nmag[k], {ppt_pkg::FracSh{1'b0}}};
                r_quo[0][k] <= '0;
                r_ovf[0][k] <= (r_nmag[k] >= {r_dmag, {ppt_pkg::FracSh{1'b0}}});
                r_dqn[0][k] <= r_qneg[k];
                r_dnn[0][k] <= r_nneg[k];
                r_dnz[0][k] <= r_nzer[k];
            end
            r_den[0] <= r_dmag;
            r_dwz[0] <= r_wzer;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: stage d resolves quotient bit QW-1-d.
    // ------------------------------------------------------------------
    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [ppt_pkg::RemW-1:0] w_dsh [3];
        logic [ppt_pkg::RemW-1:0] w_rx  [3];
        logic                     w_ge  [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                w_dsh[k] = ppt_pkg::RemW'(r_den[d]) << (QW - 1 - d);
                w_rx[k]  = ppt_pkg::RemW'(r_rem[d][k]);
                w_ge[k]  = (w_rx[k] >= w_dsh[k]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[DF+d]) begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[d+1][k] <= w_ge[k] ? ppt_pkg::NumW'(w_rx[k] - w_dsh[k])
                                             : r_rem[d][k];
                    r_quo[d+1][k] <= {r_quo[d][k][QW-2:0], w_ge[k]};
                    r_ovf[d+1][k] <= r_ovf[d][k];
                    r_dqn[d+1][k] <= r_dqn[d][k];
                    r_dnn[d+1][k] <= r_dnn[d][k];
                    r_dnz[d+1][k] <= r_dnz[d][k];
                end
                r_den[d+1] <= r_den[d];
                r_dwz[d+1] <= r_dwz[d];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation and flags.
    // ------------------------------------------------------------------
    logic [31:0] n_q [3];
    logic [2:0]  n_clip;
    logic [31:0] r_q [3];
    logic        r_wz;
    logic        r_clip;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_clip[k] = 1'b0;
            if (r_dwz[QW]) begin
                n_q[k] = r_dnz[QW][k] ? 32'h0 :
                         (r_dnn[QW][k] ? ppt_pkg::SatNeg : ppt_pkg::SatPos);
            end else if (r_dqn[QW][k]) begin
                if (r_ovf[QW][k] || r_quo[QW][k] > ppt_pkg::SatNeg) begin
                    n_q[k]    = ppt_pkg::SatNeg;
                    n_clip[k] = 1'b1;
                end else begin
                    n_q[k] = -r_quo[QW][k];
                end
            end else if (r_ovf[QW][k] || r_quo[QW][k][QW-1]) begin
                n_q[k]    = ppt_pkg::SatPos;
                n_clip[k] = 1'b1;
            end else begin
                n_q[k] = r_quo[QW][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            for (int k = 0; k < 3; k++) r_q[k] <= n_q[k];
            r_wz   <= r_dwz[QW];
            r_clip <= !r_dwz[QW] && (n_clip != 3'b000);
        end
    end

    assign m_axis_tdata = {r_q[2], r_q[1], r_q[0]};
    assign m_axis_tuser = {r_clip, r_wz};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("zero_w and clipped both set");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (r_q[0] == ppt_pkg::SatPos || r_q[0] == ppt_pkg::SatNeg ||
             r_q[1] == ppt_pkg::SatPos || r_q[1] == ppt_pkg::SatNeg ||
             r_q[2] == ppt_pkg::SatPos || r_q[2] == ppt_pkg::SatNeg))
        else $error("clipped set without a saturated lane");

    a_fill_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted beat missing from first stage");

endmodule

>>> tb/sv/tb_point_projection_transform_unit.sv
// ============================================================================
// tb_point_projection_transform_unit
// Streams points through the transform unit under several coefficient
// matrices and checks every output beat against a behavioral predictor.
// ============================================================================
module tb_point_projection_transform_unit;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 60;

    // Result item as it appears on the output stream.
    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
        logic        zero_w;
        logic        clipped;
    } t_proj;

    // One row of the directed table: a point and, where known, its result.
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          known;
        t_proj       res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata = '0;   // px[31:0], py[63:32], pz[95:64]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;        // qx[31:0], qy[63:32], qz[95:64]
    logic [1:0]    m_axis_tuser;        // zero_w[0], clipped[1]
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [ppt_pkg::AddrW-1:0] paddr = '0;
    logic [ppt_pkg::DataW-1:0] pwdata = '0;
    logic [ppt_pkg::DataW-1:0] prdata;
    logic          pready;

    point_projection_transform_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0] coef_regs [ppt_pkg::NumRegs];
    t_proj       proj_fifo [$];
    int          mism = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;   // no idling in the last part of the run
    bit          sink_on = 1'b0;

    // Exact row sum in Q32.32: c0*px + c1*py + c2*pz + c3*1.0.
    function automatic logic signed [71:0] row_total(int r, logic [31:0] x,
                                                     logic [31:0] y, logic [31:0] z);
        logic signed [71:0] acc;
        acc = $signed(coef_regs[2*r][31:0]) * $signed(x);
        acc += $signed(coef_regs[2*r][63:32]) * $signed(y);
        acc += $signed(coef_regs[2*r+1][31:0]) * $signed(z);
        acc += $signed(coef_regs[2*r+1][63:32]) * 72'sh10000;
        return acc;
    endfunction

    // Truncating divide to Q16.16 with saturation.
    function automatic logic [31:0] quotient(logic signed [71:0] n,
                                             logic signed [71:0] d, ref bit clip);
        logic signed [95:0] q;
        q = ($signed({{24{n[71]}}, n}) <<< 16) / $signed({{24{d[71]}}, d});
        if (q > 96'sh7FFFFFFF) begin
            clip = 1'b1;
            return ppt_pkg::SatPos;
        end
        if (q < -96'sh80000000) begin
            clip = 1'b1;
            return ppt_pkg::SatNeg;
        end
        return q[31:0];
    endfunction

    function automatic logic [31:0] zero_sat(logic signed [71:0] n);
        if (n == 0) return 32'h0;
        return n < 0 ? ppt_pkg::SatNeg : ppt_pkg::SatPos;
    endfunction

    function automatic t_proj project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [71:0] nx, ny, nz, w;
        t_proj r;
        bit clip;
        nx = row_total(0, x, y, z);
        ny = row_total(1, x, y, z);
        nz = row_total(2, x, y, z);
        w  = row_total(3, x, y, z);
        clip = 1'b0;
        if (w == 0) begin
            r = '{zero_sat(nx), zero_sat(ny), zero_sat(nz), 1'b1, 1'b0};
        end else begin
            r.qx = quotient(nx, w, clip);
            r.qy = quotient(ny, w, clip);
            r.qz = quotient(nz, w, clip);
            r.zero_w = 1'b0;
            r.clipped = clip;
        end
        return r;
    endfunction

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side: random stall bursts, compare each accepted beat.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_proj got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tuser[0], m_axis_tuser[1]};
            if (proj_fifo.size() == 0) begin
                mism++;
                if (mism <= 10) $display("unexpected beat %h", got);
            end else begin
                want = proj_fifo.pop_front();
                if (got !== want) begin
                    mism++;
                    if (mism <= 10)
                        $display("mismatch: expected %h %h %h z%b c%b got %h %h %h z%b c%b",
                                 want.qx, want.qy, want.qz, want.zero_w, want.clipped,
                                 got.qx, got.qy, got.qz, got.zero_w, got.clipped);
                end
            end
        end
        if (!sink_on) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic reg_write(ppt_pkg::t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ppt_pkg::AddrW'(idx) << 3; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        coef_regs[idx] = val;
    endtask

    // Send one point, with an optional random gap before it.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        proj_fifo.push_back(project(x, y, z));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_out();
        s_axis_tvalid <= 1'b0;
        while (proj_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Coefficient in a mix of magnitudes: small, unit, extreme, random.
    function automatic logic [31:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h10000;
            2: return $urandom_range(0, 1) ? ppt_pkg::SatPos : ppt_pkg::SatNeg;
            3: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 6;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? ppt_pkg::SatPos : ppt_pkg::SatNeg;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    t_row dir_tab [] = '{
        '{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
        '{32'h10000, 32'h20000, 32'hFFFF0000, 1,
          '{32'h10000, 32'h20000, 32'hFFFF0000, 1'b0, 1'b0}},
        '{ppt_pkg::SatPos, ppt_pkg::SatNeg, 32'h1, 1,
          '{ppt_pkg::SatPos, ppt_pkg::SatNeg, 32'h1, 1'b0, 1'b0}},
        '{ppt_pkg::SatNeg, ppt_pkg::SatPos, 32'hFFFFFFFF, 1,
          '{ppt_pkg::SatNeg, ppt_pkg::SatPos, 32'hFFFFFFFF, 1'b0, 1'b0}},
        '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 0, '0}
    };

    initial begin
        t_proj got_exp;
        for (int i = 0; i < ppt_pkg::NumRegs; i++) coef_regs[i] = ppt_pkg::RegRst[i];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on <= 1'b1;
        @(posedge i_clk);

        // Identity matrix after reset: points pass through.
        foreach (dir_tab[i]) begin
            send_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz);
            if (dir_tab[i].known) begin
                got_exp = proj_fifo[proj_fifo.size()-1];
                if (got_exp !== dir_tab[i].res) begin
                    mism++;
                    if (mism <= 10) $display("table row %0d disagrees with predictor", i);
                end
            end
        end
        drain_out();

        // Zero w row: every output saturates by sign or gives zero.
        reg_write(ppt_pkg::REG_ROW3_B, 64'h0);
        send_point(32'h10000, 32'hFFFF0000, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        drain_out();

        // Tiny w with big numerators: quotient overflow both ways.
        reg_write(ppt_pkg::REG_ROW3_B, 64'h0000_0001_0000_0000);
        reg_write(ppt_pkg::REG_ROW0_A, {32'h0, ppt_pkg::SatPos});
        reg_write(ppt_pkg::REG_ROW1_A, {ppt_pkg::SatNeg, 32'h0});
        send_point(ppt_pkg::SatPos, ppt_pkg::SatPos, 32'h0);
        send_point(ppt_pkg::SatNeg, ppt_pkg::SatNeg, 32'h10000);
        drain_out();
        // Negative w.
        reg_write(ppt_pkg::REG_ROW3_B, 64'hFFFF_0000_0000_0000);
        send_point(32'h30000, 32'h10000, 32'h50000);
        drain_out();

        // Random phases with random matrices, the last one all extremes.
        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < ppt_pkg::NumRegs; r++) begin
                if (ph == 7)
                    reg_write(ppt_pkg::t_reg_idx'(r), {ppt_pkg::SatNeg, ppt_pkg::SatPos});
                else
                    reg_write(ppt_pkg::t_reg_idx'(r), {rnd_coef(), rnd_coef()});
            end
            // In phase 3 force a zero w row so zero_w is common there.
            if (ph == 3) reg_write(ppt_pkg::REG_ROW3_A, 64'h0);
            if (ph == 3) reg_write(ppt_pkg::REG_ROW3_B, 64'h0);
            if (ph == 6) quiet = 1'b1;
            for (int k = 0; k < 50; k++) send_point(rnd_coord(), rnd_coord(), rnd_coord());
            drain_out();
        end

        if (mism == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
